[design/imhk_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes, command and status types for the indexed min-heap.
package imhk_pkg;

	localparam int NUM_PARTS  = 16;
	localparam int ID_SPACE   = 16;
	localparam int ID_W       = 4;
	localparam int KEY_W      = 64;
	localparam int CMD_W      = 2;
	localparam int ST_W       = 2;
	localparam int OUT_CNT_W  = 5;
	localparam int SLOT_W     = $clog2(NUM_PARTS);
	localparam int CNT_W      = $clog2(NUM_PARTS + 1);
	localparam int CH_W       = SLOT_W + 2;
	localparam int ENTRY_W    = ID_W + KEY_W;
	localparam int IN_DATA_W  = ((ID_W + KEY_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((ID_W + KEY_W + OUT_CNT_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_POP    = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE    = 2'd0,
		ST_REFUSED = 2'd1,
		ST_ABSENT  = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_LATCH,
		DP_SET_STATUS,
		DP_INSERT,
		DP_POP_RD,
		DP_POP_LD,
		DP_UPD_RD,
		DP_RM_LAST,
		DP_RM_START,
		DP_RM_LD,
		DP_UP_RD,
		DP_UP_MOVE,
		DP_WR_MOVING,
		DP_RELOAD_RD,
		DP_RELOAD_LD,
		DP_DN_RD,
		DP_DN_MOVE,
		DP_OUT
	} dp_op_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef struct packed {
		dp_op_t  op;
		status_t status;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic ins_refuse;
		logic id_absent;
		logic heap_empty;
		logic rm_at_last;
		logic pop_single;
		logic upd_up;
		logic upd_down;
		logic pos_zero;
		logic up_less;
		logic dn_leaf;
		logic dn_move;
		logic out_free;
	} dp_stat_t;

	// zero is an invalid key and wraps to the top of the order, after every nonzero key
	function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
		logic [KEY_W-1:0] am;
		logic [KEY_W-1:0] bm;
		am = a - KEY_W'(1);
		bm = b - KEY_W'(1);
		return am < bm;
	endfunction

endpackage

[design/indexed_min_heap_by_key.sv]
`timescale 1ns / 1ps
// Sequence: accept, decode, a read and a compare per heap level walked, one final
// write, one output load; refused or absent commands go straight from decode to the
// output load.
// Throughput: one word in flight; the next is taken the cycle after the result loads.
// Reset clears the presence table, entry count, state and output valid; slot
// memory is not cleared, since slots past the entry count are never read.
module indexed_min_heap_by_key (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [imhk_pkg::IN_DATA_W-1:0]    s_tdata,  // part_id, key_lsn
	input  logic [imhk_pkg::CMD_W-1:0]        s_tuser,  // cmd
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [imhk_pkg::OUT_DATA_W-1:0]   m_tdata,  // top_id, top_lsn, entry_count
	output logic [imhk_pkg::ST_W-1:0]         m_tuser   // status
);

	imhk_pkg::dp_cmd_t             dp_cmd;
	imhk_pkg::dp_stat_t            dp_stat;
	imhk_pkg::status_t             out_status;
	logic [imhk_pkg::ID_W-1:0]     out_id;
	logic [imhk_pkg::KEY_W-1:0]    out_lsn;
	logic [imhk_pkg::OUT_CNT_W-1:0] out_count;

	imhk_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.stat    (dp_stat),
		.cmd     (dp_cmd)
	);

	imhk_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.in_cmd    (imhk_pkg::cmd_t'(s_tuser)),
		.in_id     (s_tdata[imhk_pkg::ID_W-1:0]),
		.in_key    (s_tdata[imhk_pkg::ID_W +: imhk_pkg::KEY_W]),
		.out_ready (m_tready),
		.stat      (dp_stat),
		.out_valid (m_tvalid),
		.out_status(out_status),
		.out_id    (out_id),
		.out_lsn   (out_lsn),
		.out_count (out_count)
	);

	assign m_tdata = imhk_pkg::OUT_DATA_W'({out_count, out_lsn, out_id});
	assign m_tuser = out_status;

endmodule

[design/imhk_ram.sv]
`timescale 1ns / 1ps
// Generic RAM: one write port, two registered read ports.
module imhk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

[design/imhk_dpath.sv]
`timescale 1ns / 1ps
// Heap datapath: slot memory, id position table, moving entry, compares, result register.
module imhk_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  imhk_pkg::dp_cmd_t             cmd,
	input  imhk_pkg::cmd_t                in_cmd,
	input  logic [imhk_pkg::ID_W-1:0]     in_id,
	input  logic [imhk_pkg::KEY_W-1:0]    in_key,
	input  logic                          out_ready,
	output imhk_pkg::dp_stat_t            stat,
	output logic                          out_valid,
	output imhk_pkg::status_t             out_status,
	output logic [imhk_pkg::ID_W-1:0]     out_id,
	output logic [imhk_pkg::KEY_W-1:0]    out_lsn,
	output logic [imhk_pkg::OUT_CNT_W-1:0] out_count
);

	imhk_pkg::cmd_t                  cmd_q;
	logic [imhk_pkg::ID_W-1:0]       id_q;
	logic [imhk_pkg::KEY_W-1:0]      key_q;
	logic [imhk_pkg::CNT_W-1:0]      count_q;
	logic [imhk_pkg::SLOT_W-1:0]     pos_q;
	logic [imhk_pkg::SLOT_W-1:0]     orig_q;
	logic [imhk_pkg::ID_W-1:0]       mid_q;
	logic [imhk_pkg::KEY_W-1:0]      mkey_q;
	imhk_pkg::status_t               status_q;
	logic [imhk_pkg::ID_W-1:0]       top_id_q;
	logic [imhk_pkg::KEY_W-1:0]      top_lsn_q;
	logic [imhk_pkg::ID_SPACE-1:0]   present_q;
	logic [imhk_pkg::SLOT_W-1:0]     slot_tab_q [imhk_pkg::ID_SPACE];
	logic                            out_valid_q;
	imhk_pkg::status_t               out_status_q;
	logic [imhk_pkg::ID_W-1:0]       out_id_q;
	logic [imhk_pkg::KEY_W-1:0]      out_lsn_q;
	logic [imhk_pkg::OUT_CNT_W-1:0]  out_count_q;

	logic                            ram_we;
	logic [imhk_pkg::SLOT_W-1:0]     ram_waddr;
	imhk_pkg::entry_t                ram_wdata;
	logic [imhk_pkg::SLOT_W-1:0]     raddr_a;
	logic [imhk_pkg::SLOT_W-1:0]     raddr_b;
	logic [imhk_pkg::ENTRY_W-1:0]    rdata_a;
	logic [imhk_pkg::ENTRY_W-1:0]    rdata_b;
	imhk_pkg::entry_t                ent_a;
	imhk_pkg::entry_t                ent_b;

	logic [imhk_pkg::SLOT_W-1:0]     lookup;
	logic [imhk_pkg::SLOT_W-1:0]     last_slot;
	logic [imhk_pkg::SLOT_W-1:0]     parent_slot;
	logic [imhk_pkg::CH_W-1:0]       l_c;
	logic [imhk_pkg::CH_W-1:0]       r_c;
	logic                            l_ok;
	logic                            r_ok;
	logic                            l_take;
	logic                            sel_r;
	imhk_pkg::entry_t                child_ent;
	logic [imhk_pkg::SLOT_W-1:0]     child_slot;
	logic                            valid_id;

	imhk_ram #(
		.WIDTH(imhk_pkg::ENTRY_W),
		.DEPTH(imhk_pkg::NUM_PARTS)
	) u_slots (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	assign ent_a = rdata_a;
	assign ent_b = rdata_b;

	assign lookup      = slot_tab_q[id_q];
	assign last_slot   = imhk_pkg::SLOT_W'(count_q - imhk_pkg::CNT_W'(1));
	assign parent_slot = (pos_q - imhk_pkg::SLOT_W'(1)) >> 1;
	assign l_c         = imhk_pkg::CH_W'({pos_q, 1'b1});
	assign r_c         = l_c + imhk_pkg::CH_W'(1);
	assign l_ok        = l_c < imhk_pkg::CH_W'(count_q);
	assign r_ok        = r_c < imhk_pkg::CH_W'(count_q);
	assign valid_id    = 32'(id_q) < imhk_pkg::NUM_PARTS;

	// pick the smaller child; the right one wins only on a strict compare
	always_comb begin
		l_take     = l_ok && imhk_pkg::key_less(ent_a.key, mkey_q);
		sel_r      = r_ok && (l_take ? imhk_pkg::key_less(ent_b.key, ent_a.key)
		                             : imhk_pkg::key_less(ent_b.key, mkey_q));
		child_ent  = sel_r ? ent_b : ent_a;
		child_slot = sel_r ? r_c[imhk_pkg::SLOT_W-1:0] : l_c[imhk_pkg::SLOT_W-1:0];
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = '{id: mid_q, key: mkey_q};
		raddr_a   = pos_q;
		raddr_b   = pos_q;
		case (cmd.op)
			imhk_pkg::DP_POP_RD: begin
				raddr_a = '0;
				raddr_b = last_slot;
			end
			imhk_pkg::DP_UPD_RD:    raddr_a = lookup;
			imhk_pkg::DP_RM_START:  raddr_b = last_slot;
			imhk_pkg::DP_UP_RD:     raddr_a = parent_slot;
			imhk_pkg::DP_RELOAD_RD: raddr_a = orig_q;
			imhk_pkg::DP_DN_RD: begin
				raddr_a = l_c[imhk_pkg::SLOT_W-1:0];
				raddr_b = r_c[imhk_pkg::SLOT_W-1:0];
			end
			imhk_pkg::DP_UP_MOVE: begin
				ram_we    = 1'b1;
				ram_wdata = ent_a;
			end
			imhk_pkg::DP_DN_MOVE: begin
				ram_we    = 1'b1;
				ram_wdata = child_ent;
			end
			imhk_pkg::DP_WR_MOVING: ram_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			present_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				imhk_pkg::DP_INSERT: begin
					count_q         <= count_q + imhk_pkg::CNT_W'(1);
					present_q[id_q] <= 1'b1;
				end
				imhk_pkg::DP_POP_LD: begin
					count_q             <= count_q - imhk_pkg::CNT_W'(1);
					present_q[ent_a.id] <= 1'b0;
				end
				imhk_pkg::DP_RM_LAST, imhk_pkg::DP_RM_START: begin
					count_q         <= count_q - imhk_pkg::CNT_W'(1);
					present_q[id_q] <= 1'b0;
				end
				default: ;
			endcase
			if (cmd.op == imhk_pkg::DP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			imhk_pkg::DP_LATCH: begin
				cmd_q     <= in_cmd;
				id_q      <= in_id;
				key_q     <= in_key;
				status_q  <= imhk_pkg::ST_DONE;
				top_id_q  <= '0;
				top_lsn_q <= '0;
			end
			imhk_pkg::DP_SET_STATUS: status_q <= cmd.status;
			imhk_pkg::DP_INSERT: begin
				mid_q  <= id_q;
				mkey_q <= key_q;
				pos_q  <= imhk_pkg::SLOT_W'(count_q);
			end
			imhk_pkg::DP_POP_LD: begin
				top_id_q  <= ent_a.id;
				top_lsn_q <= ent_a.key;
				mid_q     <= ent_b.id;
				mkey_q    <= ent_b.key;
				pos_q     <= '0;
			end
			imhk_pkg::DP_UPD_RD: begin
				pos_q  <= lookup;
				mid_q  <= id_q;
				mkey_q <= key_q;
			end
			imhk_pkg::DP_RM_START: begin
				pos_q  <= lookup;
				orig_q <= lookup;
			end
			imhk_pkg::DP_RM_LD: begin
				mid_q  <= ent_b.id;
				mkey_q <= ent_b.key;
			end
			imhk_pkg::DP_UP_MOVE: begin
				slot_tab_q[ent_a.id] <= pos_q;
				pos_q                <= parent_slot;
			end
			imhk_pkg::DP_DN_MOVE: begin
				slot_tab_q[child_ent.id] <= pos_q;
				pos_q                    <= child_slot;
			end
			imhk_pkg::DP_WR_MOVING: slot_tab_q[mid_q] <= pos_q;
			imhk_pkg::DP_RELOAD_LD: begin
				mid_q  <= ent_a.id;
				mkey_q <= ent_a.key;
				pos_q  <= orig_q;
			end
			imhk_pkg::DP_OUT: begin
				out_status_q <= status_q;
				out_id_q     <= top_id_q;
				out_lsn_q    <= top_lsn_q;
				out_count_q  <= imhk_pkg::OUT_CNT_W'(count_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.cmd        = cmd_q;
		stat.ins_refuse = (key_q == '0) || (32'(count_q) >= imhk_pkg::NUM_PARTS)
		                  || !valid_id || present_q[id_q];
		stat.id_absent  = !valid_id || !present_q[id_q];
		stat.heap_empty = count_q == '0;
		stat.rm_at_last = imhk_pkg::CNT_W'(lookup) == (count_q - imhk_pkg::CNT_W'(1));
		stat.pop_single = count_q == imhk_pkg::CNT_W'(1);
		stat.upd_up     = imhk_pkg::key_less(key_q, ent_a.key);
		stat.upd_down   = imhk_pkg::key_less(ent_a.key, key_q);
		stat.pos_zero   = pos_q == '0;
		stat.up_less    = imhk_pkg::key_less(mkey_q, ent_a.key);
		stat.dn_leaf    = !l_ok;
		stat.dn_move    = l_take || sel_r;
		stat.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_id     = out_id_q;
	assign out_lsn    = out_lsn_q;
	assign out_count  = out_count_q;

endmodule

[design/imhk_ctrl.sv]
`timescale 1ns / 1ps
// Heap controller: sequences decode, sift up, sift down and the result hand-off.
module imhk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  imhk_pkg::dp_stat_t stat,
	output imhk_pkg::dp_cmd_t  cmd
);

	typedef enum logic [11:0] {
		S_IDLE      = 12'b000000000001,
		S_DECODE    = 12'b000000000010,
		S_POP_LD    = 12'b000000000100,
		S_UPD_LD    = 12'b000000001000,
		S_RM_LD     = 12'b000000010000,
		S_UP_RD     = 12'b000000100000,
		S_UP_CMP    = 12'b000001000000,
		S_RELOAD_RD = 12'b000010000000,
		S_RELOAD_LD = 12'b000100000000,
		S_DN_RD     = 12'b001000000000,
		S_DN_CMP    = 12'b010000000000,
		S_RESP      = 12'b100000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t up_done;

	// a removal sifts down from the hole once its sift up ends
	assign up_done  = (stat.cmd == imhk_pkg::CMD_REMOVE) ? S_RELOAD_RD : S_RESP;
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d    = state_q;
		cmd.op     = imhk_pkg::DP_NOP;
		cmd.status = imhk_pkg::ST_DONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = imhk_pkg::DP_LATCH;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.cmd)
					imhk_pkg::CMD_INSERT: begin
						if (stat.ins_refuse) begin
							cmd.op     = imhk_pkg::DP_SET_STATUS;
							cmd.status = imhk_pkg::ST_REFUSED;
							state_d    = S_RESP;
						end else begin
							cmd.op  = imhk_pkg::DP_INSERT;
							state_d = S_UP_RD;
						end
					end
					imhk_pkg::CMD_POP: begin
						if (stat.heap_empty) begin
							cmd.op     = imhk_pkg::DP_SET_STATUS;
							cmd.status = imhk_pkg::ST_EMPTY;
							state_d    = S_RESP;
						end else begin
							cmd.op  = imhk_pkg::DP_POP_RD;
							state_d = S_POP_LD;
						end
					end
					imhk_pkg::CMD_UPDATE: begin
						if (stat.id_absent) begin
							cmd.op     = imhk_pkg::DP_SET_STATUS;
							cmd.status = imhk_pkg::ST_ABSENT;
							state_d    = S_RESP;
						end else begin
							cmd.op  = imhk_pkg::DP_UPD_RD;
							state_d = S_UPD_LD;
						end
					end
					imhk_pkg::CMD_REMOVE: begin
						if (stat.id_absent) begin
							cmd.op     = imhk_pkg::DP_SET_STATUS;
							cmd.status = imhk_pkg::ST_ABSENT;
							state_d    = S_RESP;
						end else if (stat.rm_at_last) begin
							cmd.op  = imhk_pkg::DP_RM_LAST;
							state_d = S_RESP;
						end else begin
							cmd.op  = imhk_pkg::DP_RM_START;
							state_d = S_RM_LD;
						end
					end
					default: state_d = S_RESP;
				endcase
			end
			S_POP_LD: begin
				cmd.op  = imhk_pkg::DP_POP_LD;
				state_d = stat.pop_single ? S_RESP : S_DN_RD;
			end
			S_UPD_LD: begin
				if (stat.upd_up) begin
					state_d = S_UP_RD;
				end else if (stat.upd_down) begin
					state_d = S_DN_RD;
				end else begin
					state_d = S_RESP;
				end
			end
			S_RM_LD: begin
				cmd.op  = imhk_pkg::DP_RM_LD;
				state_d = S_UP_RD;
			end
			S_UP_RD: begin
				if (stat.pos_zero) begin
					cmd.op  = imhk_pkg::DP_WR_MOVING;
					state_d = up_done;
				end else begin
					cmd.op  = imhk_pkg::DP_UP_RD;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.up_less) begin
					cmd.op  = imhk_pkg::DP_UP_MOVE;
					state_d = S_UP_RD;
				end else begin
					cmd.op  = imhk_pkg::DP_WR_MOVING;
					state_d = up_done;
				end
			end
			S_RELOAD_RD: begin
				cmd.op  = imhk_pkg::DP_RELOAD_RD;
				state_d = S_RELOAD_LD;
			end
			S_RELOAD_LD: begin
				cmd.op  = imhk_pkg::DP_RELOAD_LD;
				state_d = S_DN_RD;
			end
			S_DN_RD: begin
				if (stat.dn_leaf) begin
					cmd.op  = imhk_pkg::DP_WR_MOVING;
					state_d = S_RESP;
				end else begin
					cmd.op  = imhk_pkg::DP_DN_RD;
					state_d = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (stat.dn_move) begin
					cmd.op  = imhk_pkg::DP_DN_MOVE;
					state_d = S_DN_RD;
				end else begin
					cmd.op  = imhk_pkg::DP_WR_MOVING;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				// hold until the output register has room
				if (stat.out_free) begin
					cmd.op  = imhk_pkg::DP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/imhk_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the indexed min-heap, bound to the top level.
module imhk_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [imhk_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [imhk_pkg::ST_W-1:0]       m_tuser
);

	// one word at a time: an accepted word closes the input for the next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
	else $error("input accepted while a word is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	else $error("stalled result changed");

	a_fail_no_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != imhk_pkg::ST_DONE)
		|-> m_tdata[imhk_pkg::ID_W + imhk_pkg::KEY_W - 1:0] == '0)
	else $error("top entry reported on a failed command");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == imhk_pkg::ST_EMPTY)
		|-> m_tdata[imhk_pkg::ID_W + imhk_pkg::KEY_W +: imhk_pkg::OUT_CNT_W] == '0)
	else $error("empty pop with nonzero entry count");

endmodule

bind indexed_min_heap_by_key imhk_checker u_imhk_checker (.*);
